// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL; clock is clk, reset is arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- sv/gtcr_pkg.sv -----
`timescale 1ns / 1ps
package gtcr_pkg;

	// Command word opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PUT  = 1'b1;

	// Control characters
	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	// Tab stop and its reciprocal: x / 5 == (x * 205) >> 10 for 8-bit x
	localparam logic [2:0] TAB_STOP   = 3'd5;
	localparam logic [7:0] TAB_RECIP  = 8'd205;
	localparam int         TAB_SHIFT  = 10;

	// Glyph limits
	localparam logic [3:0] GLYPH_W_MAX  = 4'd8;
	localparam int         GLYPH_H_MAX  = 16;

	// Configuration register indexes
	localparam logic [2:0] CFG_SCANLINE_BYTES = 3'd0;
	localparam logic [2:0] CFG_PIXEL_BYTES    = 3'd1;
	localparam logic [2:0] CFG_GLYPH_WIDTH    = 3'd2;
	localparam logic [2:0] CFG_GLYPH_HEIGHT   = 3'd3;
	localparam logic [2:0] CFG_TEXT_COLUMNS   = 3'd4;
	localparam logic [2:0] CFG_TEXT_ROWS      = 3'd5;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
		logic [3:0] load_row;
		logic [7:0] load_bits;
	} cmd_t;

	typedef struct packed {
		logic [31:0] row_offset;
		logic [8:0]  row_mask;
		logic [3:0]  row_pixels;
		logic        last_row;
	} pix_t;

endpackage

// ----- sv/gtcr_font_store.sv -----
`timescale 1ns / 1ps
module gtcr_font_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write one glyph row byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read, every cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/glyph_text_console_renderer_unit.sv -----
// Text console renderer: cmd words either load one glyph row byte into the
// font store (taken every cycle, no result) or put one character at the cursor.
// A drawn glyph yields one pix word per glyph row: four passes through the one
// shared 16x16 multiplier build the start offset, a fetch state primes the font
// store read port, one row leaves per cycle unless pix_stall holds the output,
// and an update state moves the cursor. A tab makes one multiplier pass for the
// mod-5 step before its update; a newline goes straight to the update. The
// block holds cmd_stall high while a character is in work; a finished pix
// word waits in its output register while the next cmd is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glyph_text_console_renderer_unit
	import gtcr_pkg::*;
#(
	parameter int GLYPH_COUNT    = 256,
	parameter int MAX_GLYPH_ROWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        pix_valid,
	input  logic        pix_stall,
	output pix_t        pix,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int HCAP  = (MAX_GLYPH_ROWS < GLYPH_H_MAX) ? MAX_GLYPH_ROWS : GLYPH_H_MAX;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RH,
		ST_MUL_S,
		ST_MUL_CW,
		ST_MUL_P,
		ST_FETCH,
		ST_EMIT,
		ST_TAB,
		ST_UPDATE
	} state_t;

	typedef enum logic [1:0] {
		K_NEWLINE,
		K_TAB,
		K_GLYPH
	} kind_t;

	state_t state_q;
	kind_t  kind_q;

	logic [15:0] scanline_bytes_q;
	logic [2:0]  pixel_bytes_q;
	logic [3:0]  glyph_width_q;
	logic [4:0]  glyph_height_q;
	logic [7:0]  text_columns_q;
	logic [7:0]  text_rows_q;

	logic [7:0]    col_q;
	logic [7:0]    row_q;
	logic [AW-1:0] base_q;
	logic [4:0]    r_q;
	logic [31:0]   prod_q;
	logic [31:0]   off_q;
	pix_t          pix_q;
	logic          pix_valid_q;

	logic          cmd_fire;
	logic          emit_fire;
	logic          last;
	logic [3:0]    w_eff;
	logic [4:0]    h_eff;
	logic [15:0]   mul_a;
	logic [15:0]   mul_b;
	logic [31:0]   mul_p;
	logic          code_ok;
	logic [7:0]    g_code;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [4:0]    rd_row;
	logic [7:0]    rd_data;
	logic [8:0]    mask;
	logic [5:0]    tab_q6;
	logic [7:0]    tab_q5;
	logic [2:0]    tab_rem;
	logic [8:0]    col_adv;
	logic [8:0]    row_adv;
	logic [7:0]    col_nxt;
	logic [7:0]    row_nxt;

	// Handshake
	assign cmd_fire  = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);
	assign emit_fire = (state_q == ST_EMIT) && (!pix_valid_q || !pix_stall);
	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;
	assign cfg_ready = 1'b1;

	// Effective glyph size: width saturated to 1..8, height capped
	always_comb begin
		if (glyph_width_q == 4'd0) begin
			w_eff = 4'd1;
		end else if (glyph_width_q > GLYPH_W_MAX) begin
			w_eff = GLYPH_W_MAX;
		end else begin
			w_eff = glyph_width_q;
		end
		h_eff = (glyph_height_q > 5'(HCAP)) ? 5'(HCAP) : glyph_height_q;
	end

	assign last = ((r_q + 5'd1) == h_eff);

	// Font store addressing; codes beyond the font draw glyph 0
	assign code_ok = ({2'b00, cmd.char_code} < 10'(GLYPH_COUNT));
	assign g_code  = code_ok ? cmd.char_code : 8'd0;
	assign wr_en   = cmd_fire && (cmd.opcode == OP_LOAD) && code_ok
		&& ({2'b00, cmd.load_row} < 6'(MAX_GLYPH_ROWS));
	assign wr_addr = AW'(32'(cmd.char_code) * 32'(MAX_GLYPH_ROWS) + 32'(cmd.load_row));
	assign rd_row  = (emit_fire && !last) ? (r_q + 5'd1) : r_q;
	assign rd_addr = base_q + AW'(rd_row);

	gtcr_font_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_font (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(cmd.load_bits),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_MUL_RH: begin
				mul_a = {8'd0, row_q};
				mul_b = {11'd0, h_eff};
			end
			ST_MUL_S: begin
				mul_a = prod_q[15:0];
				mul_b = scanline_bytes_q;
			end
			ST_MUL_CW: begin
				mul_a = {8'd0, col_q};
				mul_b = {12'd0, w_eff + 4'd1};
			end
			ST_MUL_P: begin
				mul_a = prod_q[15:0];
				mul_b = {13'd0, pixel_bytes_q};
			end
			ST_TAB: begin
				mul_a = {8'd0, col_q};
				mul_b = {8'd0, TAB_RECIP};
			end
			default: begin
				mul_a = 16'd0;
				mul_b = 16'd0;
			end
		endcase
	end

	assign mul_p = 32'(mul_a) * 32'(mul_b);

	// Mirror the glyph row: pixel k takes bit W-1-k
	always_comb begin
		logic [3:0] idx;
		mask = 9'd0;
		for (int k = 0; k < 8; k++) begin
			idx = w_eff - 4'd1 - 4'(k);
			if (4'(k) < w_eff) begin
				mask[k] = rd_data[idx[2:0]];
			end
		end
	end

	// Cursor advance, wrap and clamp
	always_comb begin
		tab_q6  = prod_q[TAB_SHIFT +: 6];
		tab_q5  = {tab_q6, 2'b00} + {2'b00, tab_q6};
		tab_rem = 3'(col_q - tab_q5);
		case (kind_q)
			K_NEWLINE: begin
				col_adv = 9'd0;
				row_adv = {1'b0, row_q} + 9'd1;
			end
			K_TAB: begin
				col_adv = {1'b0, col_q} + 9'(TAB_STOP) - 9'(tab_rem);
				row_adv = {1'b0, row_q};
			end
			default: begin
				col_adv = {1'b0, col_q} + 9'd1;
				row_adv = {1'b0, row_q};
			end
		endcase
		if (col_adv >= {1'b0, text_columns_q}) begin
			col_adv = 9'd0;
			row_adv = row_adv + 9'd1;
		end
		if (row_adv > {1'b0, text_rows_q}) begin
			col_adv = 9'd0;
			row_adv = {1'b0, text_rows_q};
		end
		col_nxt = col_adv[7:0];
		row_nxt = row_adv[7:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scanline_bytes_q <= 16'd4096;
			pixel_bytes_q    <= 3'd4;
			glyph_width_q    <= 4'd8;
			glyph_height_q   <= 5'd16;
			text_columns_q   <= 8'd80;
			text_rows_q      <= 8'd25;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SCANLINE_BYTES: scanline_bytes_q <= cfg_data;
				CFG_PIXEL_BYTES:    pixel_bytes_q    <= cfg_data[2:0];
				CFG_GLYPH_WIDTH:    glyph_width_q    <= cfg_data[3:0];
				CFG_GLYPH_HEIGHT:   glyph_height_q   <= cfg_data[4:0];
				CFG_TEXT_COLUMNS:   text_columns_q   <= cfg_data[7:0];
				CFG_TEXT_ROWS:      text_rows_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer, cursor and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= K_GLYPH;
			col_q       <= 8'd0;
			row_q       <= 8'd0;
			base_q      <= '0;
			r_q         <= 5'd0;
			prod_q      <= 32'd0;
			off_q       <= 32'd0;
			pix_q       <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			// hold a stalled word, drop a taken one, load a new one on emit
			pix_valid_q <= emit_fire || (pix_valid_q && pix_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.opcode == OP_PUT)) begin
						r_q    <= 5'd0;
						base_q <= AW'(32'(g_code) * 32'(MAX_GLYPH_ROWS));
						if (cmd.char_code == CHAR_NEWLINE) begin
							kind_q  <= K_NEWLINE;
							state_q <= ST_UPDATE;
						end else if (cmd.char_code == CHAR_TAB) begin
							kind_q  <= K_TAB;
							state_q <= ST_TAB;
						end else begin
							kind_q  <= K_GLYPH;
							state_q <= (h_eff == 5'd0) ? ST_UPDATE : ST_MUL_RH;
						end
					end
				end
				ST_MUL_RH: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL_S;
				end
				ST_MUL_S: begin
					prod_q  <= mul_p;
					state_q <= ST_MUL_CW;
				end
				ST_MUL_CW: begin
					off_q   <= prod_q;
					prod_q  <= mul_p;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					prod_q  <= mul_p;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					off_q   <= off_q + prod_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						pix_q.row_offset <= off_q;
						pix_q.row_mask   <= mask;
						pix_q.row_pixels <= w_eff + 4'd1;
						pix_q.last_row   <= last;
						off_q            <= off_q + {16'd0, scanline_bytes_q};
						r_q              <= r_q + 5'd1;
						if (last) begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_TAB: begin
					prod_q  <= mul_p;
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					col_q   <= col_nxt;
					row_q   <= row_nxt;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A put keeps the block busy; a load leaves it ready
	`ASSERT_NEXT(a_put_busy, cmd_valid && !cmd_stall && (cmd.opcode == OP_PUT), cmd_stall)
	`ASSERT_NEXT(a_load_ready, cmd_valid && !cmd_stall && (cmd.opcode == OP_LOAD), !cmd_stall)
	// Every pix word spans 2..9 pixels with the trailing pixel in background
	`ASSERT_IMPLY(a_pix_shape, pix_valid, (pix.row_pixels >= 4'd2) && (pix.row_pixels <= 4'd9) && !pix.row_mask[8])

endmodule

// ----- tb/glyph_text_console_renderer_unit_tb.sv -----
`timescale 1ns / 1ps
module glyph_text_console_renderer_unit_tb;
	import gtcr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int PRINT_CAP    = 50;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one directed row: the word, and optionally the typed-in first pix word
	typedef struct packed {
		cmd_t w;
		logic typed;
		pix_t first;
	} plan_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cmd_t        cmd       = '0;
	logic        pix_valid;
	logic        pix_stall = 1'b0;
	pix_t        pix;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_SCANLINE_BYTES;
	logic [15:0] cfg_data  = '0;

	// register, cursor and font copies kept by the predictor
	logic [15:0] r_scan    = 16'd4096;
	logic [2:0]  r_pbytes  = 3'd4;
	logic [3:0]  r_gwidth  = 4'd8;
	logic [4:0]  r_gheight = 5'd16;
	logic [7:0]  r_cols    = 8'd80;
	logic [7:0]  r_rows    = 8'd25;
	logic [7:0]  cur_col   = '0;
	logic [7:0]  cur_row   = '0;
	logic [7:0]  font_rows   [256][16];
	bit          font_loaded [256][16];

	pix_t rows_due[$];
	pix_t want;
	int   words_sent;
	int   rows_checked;
	int   mismatches;
	int   phases_run;
	int   cycle_count;
	int   send_pct;
	int   stall_pct;
	int   hold_seq;
	int   hold_seen;
	int   hold_left;

	// directed words, run with the reset settings
	plan_row_t plan [20] = '{
		'{'{OP_LOAD, 8'h41, 4'd0,  8'h81}, 1'b0, '0},
		'{'{OP_LOAD, 8'h41, 4'd1,  8'h55}, 1'b0, '0},
		'{'{OP_PUT,  8'h41, 4'd0,  8'h00}, 1'b1, '{32'd0, 9'h081, 4'd9, 1'b0}},
		'{'{OP_LOAD, 8'hFF, 4'd15, 8'hFF}, 1'b0, '0},
		'{'{OP_LOAD, 8'hFF, 4'd0,  8'h00}, 1'b0, '0},
		'{'{OP_PUT,  8'hFF, 4'd15, 8'hFF}, 1'b1, '{32'd36, 9'h000, 4'd9, 1'b0}},
		'{'{OP_PUT,  CHAR_TAB, 4'd0, 8'h00}, 1'b0, '0},
		'{'{OP_PUT,  CHAR_TAB, 4'd0, 8'h00}, 1'b0, '0},
		'{'{OP_LOAD, 8'h00, 4'd0,  8'hF0}, 1'b0, '0},
		'{'{OP_PUT,  8'h00, 4'd0,  8'h00}, 1'b1, '{32'd360, 9'h00F, 4'd9, 1'b0}},
		'{'{OP_PUT,  CHAR_NEWLINE, 4'd0, 8'h00}, 1'b0, '0},
		'{'{OP_PUT,  8'h41, 4'd0,  8'h00}, 1'b1, '{32'd65536, 9'h081, 4'd9, 1'b0}},
		'{'{OP_LOAD, 8'h20, 4'd7,  8'hAA}, 1'b0, '0},
		'{'{OP_LOAD, 8'h20, 4'd0,  8'hFF}, 1'b0, '0},
		'{'{OP_PUT,  8'h20, 4'd0,  8'h00}, 1'b1, '{32'd65572, 9'h0FF, 4'd9, 1'b0}},
		'{'{OP_PUT,  CHAR_NEWLINE, 4'd0, 8'h00}, 1'b0, '0},
		'{'{OP_PUT,  CHAR_TAB, 4'd0, 8'h00}, 1'b0, '0},
		'{'{OP_PUT,  8'h20, 4'd0,  8'h00}, 1'b0, '0},
		'{'{OP_LOAD, CHAR_TAB, 4'd3, 8'h3C}, 1'b0, '0},
		'{'{OP_PUT,  CHAR_NEWLINE, 4'd0, 8'h00}, 1'b0, '0}
	};

	glyph_text_console_renderer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Work out the pix words one accepted word causes and advance the cursor.
	function automatic void render_word(input cmd_t w, input bit typed, input pix_t first);
		int unsigned col;
		int unsigned row;
		int unsigned gw;
		int unsigned gh;
		logic [31:0] offs;
		logic [7:0]  bits;
		pix_t        p;
		if (w.opcode == OP_LOAD) begin
			font_rows[w.char_code][w.load_row] = w.load_bits;
			font_loaded[w.char_code][w.load_row] = 1'b1;
			return;
		end
		col = cur_col;
		row = cur_row;
		if (w.char_code == CHAR_NEWLINE) begin
			col = 0;
			row++;
		end else if (w.char_code == CHAR_TAB) begin
			col += TAB_STOP - col % TAB_STOP;
		end else begin
			// saturate glyph size into the drawable range
			gw = (r_gwidth == 0) ? 1 : (r_gwidth > GLYPH_W_MAX) ? GLYPH_W_MAX : r_gwidth;
			gh = (r_gheight > GLYPH_H_MAX) ? GLYPH_H_MAX : r_gheight;
			offs = row * gh * r_scan + col * (gw + 1) * r_pbytes;
			for (int unsigned r = 0; r < gh; r++) begin
				bits = font_rows[w.char_code][r];
				p.row_offset = offs;
				p.row_mask = '0;
				// leftmost pixel comes from the top bit of the glyph width
				for (int unsigned k = 0; k < gw; k++)
					p.row_mask[k] = bits[gw - 1 - k];
				p.row_pixels = 4'(gw + 1);
				p.last_row = (r + 1 == gh);
				rows_due.push_back((typed && r == 0) ? first : p);
				offs += r_scan;
			end
			col++;
		end
		// wrap a full line, then clamp below the last row
		if (col >= r_cols) begin
			col = 0;
			row++;
		end
		if (row > r_rows) begin
			col = 0;
			row = r_rows;
		end
		cur_col = col[7:0];
		cur_row = row[7:0];
	endfunction

	// Offer one word after a random gap and hold it until taken.
	task automatic put_word(input cmd_t w, input bit typed = 1'b0, input pix_t first = '0);
		while ($urandom_range(99) < send_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
		render_word(w, typed, first);
	endtask

	// Load every font row of a glyph that has not been written yet.
	task automatic load_missing_rows(input logic [7:0] code);
		cmd_t w;
		if (code == CHAR_TAB || code == CHAR_NEWLINE)
			return;
		for (int r = 0; r < GLYPH_H_MAX; r++) begin
			if (!font_loaded[code][r]) begin
				w.opcode = OP_LOAD;
				w.char_code = code;
				w.load_row = 4'(r);
				w.load_bits = 8'($urandom);
				put_word(w);
			end
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SCANLINE_BYTES: r_scan = val;
			CFG_PIXEL_BYTES:    r_pbytes = val[2:0];
			CFG_GLYPH_WIDTH:    r_gwidth = val[3:0];
			CFG_GLYPH_HEIGHT:   r_gheight = val[4:0];
			CFG_TEXT_COLUMNS:   r_cols = val[7:0];
			CFG_TEXT_ROWS:      r_rows = val[7:0];
			default: ;
		endcase
	endtask

	// Drop valid, wait for every expected word, then let the block go idle.
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (rows_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly glyph draws from the loaded glyphs, some control codes, some stray loads.
	task automatic random_word();
		cmd_t       w;
		int         pick;
		logic [7:0] pool_code;
		pick = $urandom_range(99);
		case ($urandom_range(3))
			0:       pool_code = 8'h00;
			1:       pool_code = 8'h20;
			2:       pool_code = 8'h41;
			default: pool_code = 8'hFF;
		endcase
		w.char_code = 8'($urandom);
		w.load_row = 4'($urandom);
		w.load_bits = 8'($urandom);
		if (pick < 12) begin
			w.opcode = OP_LOAD;
			// half the loads rewrite a glyph that draws use
			if (pick < 6)
				w.char_code = pool_code;
		end else begin
			w.opcode = OP_PUT;
			if (pick < 20)
				w.char_code = CHAR_NEWLINE;
			else if (pick < 28)
				w.char_code = CHAR_TAB;
			else
				w.char_code = pool_code;
			load_missing_rows(w.char_code);
		end
		put_word(w);
	endtask

	task automatic run_phase(input logic [15:0] scan, input logic [2:0] pbytes,
		input logic [3:0] gwidth, input logic [4:0] gheight, input logic [7:0] cols,
		input logic [7:0] rows, input idle_mode_t mode, input int count,
		input int pause_at, input bit hold);
		settle();
		// narrow registers get junk in the unused upper bits
		write_reg(CFG_SCANLINE_BYTES, scan);
		write_reg(CFG_PIXEL_BYTES, {13'($urandom), pbytes});
		write_reg(CFG_GLYPH_WIDTH, {12'($urandom), gwidth});
		write_reg(CFG_GLYPH_HEIGHT, {11'($urandom), gheight});
		write_reg(CFG_TEXT_COLUMNS, {8'($urandom), cols});
		write_reg(CFG_TEXT_ROWS, {8'($urandom), rows});
		cfg_valid <= 1'b0;
		phases_run++;
		case (mode)
			IDLE_NONE:     begin send_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_pct = 75; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_pct = 0;  stall_pct = 75; end
			default:       begin send_pct = 10; stall_pct = 10; end
		endcase
		if (hold)
			hold_seq++;
		for (int i = 0; i < count; i++) begin
			// hold the sender back until the block has drained
			if (i == pause_at) begin
				cmd_valid <= 1'b0;
				do @(posedge clk); while (rows_due.size() != 0);
			end
			random_word();
		end
	endtask

	// Drive pix_stall: a counted hold-off when asked, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check each taken pix word against the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) begin
			if (rows_due.size() == 0) begin
				report_mismatch("pix word with no row expected");
			end else begin
				want = rows_due.pop_front();
				if (pix.row_offset !== want.row_offset)
					report_mismatch($sformatf("row_offset %h, expected %h",
						pix.row_offset, want.row_offset));
				if (pix.row_mask !== want.row_mask)
					report_mismatch($sformatf("row_mask %h, expected %h",
						pix.row_mask, want.row_mask));
				if (pix.row_pixels !== want.row_pixels)
					report_mismatch($sformatf("row_pixels %0d, expected %0d",
						pix.row_pixels, want.row_pixels));
				if (pix.last_row !== want.last_row)
					report_mismatch($sformatf("last_row %b, expected %b",
						pix.last_row, want.last_row));
				rows_checked++;
			end
		end
	end

	// Stop a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d rows still expected",
			cycle_count, rows_due.size());
		$display("glyph_text_console_renderer_unit_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fonts for the directed words, then the directed words themselves
		load_missing_rows(8'h00);
		load_missing_rows(8'h20);
		load_missing_rows(8'h41);
		load_missing_rows(8'hFF);
		foreach (plan[i])
			put_word(plan[i].w, plan[i].typed, plan[i].first);

		run_phase(16'd640, 3'd1, 4'd5, 5'd4, 8'd16, 8'd6, IDLE_NONE, 45, 30, 1'b0);
		run_phase(16'd65535, 3'd4, 4'd8, 5'd16, 8'd255, 8'd255, IDLE_SENDER, 30, -1, 1'b1);
		run_phase(16'd1, 3'd1, 4'd1, 5'd1, 8'd1, 8'd1, IDLE_RECEIVER, 40, -1, 1'b0);
		run_phase(16'd100, 3'd3, 4'd0, 5'd0, 8'd7, 8'd3, IDLE_BOTH, 40, -1, 1'b0);
		run_phase(16'd2048, 3'd2, 4'd15, 5'd31, 8'd0, 8'd0, IDLE_NONE, 20, -1, 1'b0);
		run_phase(16'd320, 3'd7, 4'd3, 5'd2, 8'd5, 8'd2, IDLE_SENDER, 40, -1, 1'b0);
		run_phase(16'd800, 3'd0, 4'd6, 5'd3, 8'd12, 8'd4, IDLE_RECEIVER, 40, -1, 1'b0);
		run_phase(16'($urandom), 3'($urandom), 4'($urandom), 5'($urandom_range(8)),
			8'($urandom), 8'($urandom), IDLE_BOTH, 45, -1, 1'b0);
		run_phase(16'd4096, 3'd4, 4'd8, 5'd2, 8'd80, 8'd25, IDLE_NONE, 36, 25, 1'b0);

		settle();
		if (rows_due.size() != 0)
			report_mismatch($sformatf("%0d rows never arrived", rows_due.size()));
		$display("sent %0d command words over %0d register settings, checked %0d pix words",
			words_sent, phases_run, rows_checked);
		$display("covered tabs, newlines, wrap and clamp, odd glyph sizes, stalls and a hold-off");
		if (mismatches == 0) begin
			$display("glyph_text_console_renderer_unit_tb OK");
		end else begin
			$display("glyph_text_console_renderer_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
